>>> rtl/core/ts2ep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timestamp to epoch-nanoseconds block.
// Used by ts2ep_ctrl, ts2ep_dpath and iso_timestamp_to_epoch_nanos; no dependencies.
package ts2ep_pkg;

  // Number of fraction digits in the string (1..9).
  localparam int FRACTION_DIGITS = 9;

  localparam int OFF_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int FRAC_W  = 30;
  localparam int DIGIT_W = 4;

  // Calendar datapath widths
  localparam int YP_W     = 14;  // year shifted by 400, 399..10407
  localparam int MI_W     = 4;   // month index 0..11, January = 0
  localparam int HMS_W    = 19;  // hour*3600 + minute*60 + second, up to 362439
  localparam int Y365_W   = 22;
  localparam int Q4_W     = YP_W - 2;
  localparam int Q100_W   = 7;
  localparam int Q400_W   = 5;
  localparam int RECIP_W  = 13;
  localparam int PQ_W     = YP_W + RECIP_W;
  localparam int M12_W    = 15;
  localparam int DOY_W    = 9;
  localparam int DAYS_W   = 24;  // signed day count
  localparam int SECS_W   = 40;  // signed second count
  localparam int NS_W     = 30;
  localparam int HALF_W   = 32;
  localparam int MULP_W   = HALF_W + NS_W;
  localparam int EPOCH_W  = 64;

  // Character offsets of the fixed layout
  localparam logic [OFF_W-1:0] OFF_YEAR_END = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_MON0     = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_MON1     = OFF_W'(6);
  localparam logic [OFF_W-1:0] OFF_DAY0     = OFF_W'(8);
  localparam logic [OFF_W-1:0] OFF_DAY1     = OFF_W'(9);
  localparam logic [OFF_W-1:0] OFF_HOUR0    = OFF_W'(11);
  localparam logic [OFF_W-1:0] OFF_HOUR1    = OFF_W'(12);
  localparam logic [OFF_W-1:0] OFF_MIN0     = OFF_W'(14);
  localparam logic [OFF_W-1:0] OFF_MIN1     = OFF_W'(15);
  localparam logic [OFF_W-1:0] OFF_SEC0     = OFF_W'(17);
  localparam logic [OFF_W-1:0] OFF_SEC1     = OFF_W'(18);
  localparam logic [OFF_W-1:0] OFF_FRAC0    = OFF_W'(20);
  localparam logic [OFF_W-1:0] OFF_LAST     = OFF_W'(19 + FRACTION_DIGITS);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Scale of the fraction field to nanoseconds
  localparam logic [FRAC_W-1:0] FRAC_SCALE = FRAC_W'(pow10(9 - FRACTION_DIGITS));

  localparam logic [NS_W-1:0]    NANOS_PER_SEC = NS_W'(1000000000);
  localparam logic [17:0]        SECS_PER_DAY  = 18'd86400;
  localparam logic [HMS_W-1:0]   SECS_PER_HOUR = HMS_W'(3600);
  localparam logic [HMS_W-1:0]   SECS_PER_MIN  = HMS_W'(60);
  localparam logic [Y365_W-1:0]  DAYS_PER_YEAR = Y365_W'(365);
  localparam logic [M12_W-1:0]   MONTHS_PER_YEAR = M12_W'(12);
  localparam logic [M12_W-1:0]   RECIP_12      = M12_W'(171);   // 2^11 / 12, rounded up
  localparam int                 RECIP_12_SH   = 11;
  localparam logic [PQ_W-1:0]    RECIP_100     = PQ_W'(5243);   // 2^19 / 100, rounded up
  localparam int                 RECIP_100_SH  = 19;
  localparam logic [YP_W:0]      YEAR_SHIFT    = (YP_W + 1)'(400);
  // Days from the March-based year origin (shifted by one 400-year cycle) to 1970-01-01
  localparam logic [DAYS_W-1:0]  DAY_BIAS      = DAYS_W'(865565);
  localparam logic [MI_W-1:0]    MI_DEC        = MI_W'(11);
  localparam logic [MI_W-1:0]    MI_MAR        = MI_W'(2);

  // Days from March 1 to the first of month index mi (January = 0)
  function automatic logic [DOY_W-1:0] month_day_offset(input logic [MI_W-1:0] mi);
    logic [DOY_W-1:0] d;
    case (mi)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic char_en;
    logic ld_norm;
    logic ld_div;
    logic ld_days;
    logic ld_secs;
    logic mul_lo;
    logic mul_hi;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_char;
    logic out_full;
  } dp_stat_t;

endpackage

>>> rtl/core/ts2ep_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the timestamp converter: character intake, then the calendar steps.
// Depends on ts2ep_pkg.
module ts2ep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  ts2ep_pkg::dp_stat_t stat,
  output ts2ep_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_NORM   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_DAYS   = 8'b0000_1000,
    S_SECS   = 8'b0001_0000,
    S_MUL_LO = 8'b0010_0000,
    S_MUL_HI = 8'b0100_0000,
    S_SUM    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.char_en = in_valid && in_ready;
    cmd.ld_norm = (state == S_NORM);
    cmd.ld_div  = (state == S_DIV);
    cmd.ld_days = (state == S_DAYS);
    cmd.ld_secs = (state == S_SECS);
    cmd.mul_lo  = (state == S_MUL_LO);
    cmd.mul_hi  = (state == S_MUL_HI);
    cmd.ld_out  = (state == S_SUM) && (!stat.out_full || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.char_en && stat.last_char) begin
          state_next = S_NORM;
        end
      end
      S_NORM:   state_next = S_DIV;
      S_DIV:    state_next = S_DAYS;
      S_DAYS:   state_next = S_SECS;
      S_SECS:   state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SUM;
      S_SUM: begin
        if (cmd.ld_out) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (cmd.char_en && stat.last_char) |=> !in_ready)
    else $error("intake not stalled after final character");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> ##6 (state == S_SUM))
    else $error("calendar steps out of sequence");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |=> stat.out_full)
    else $error("result load did not raise output valid");

  a_no_char_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> !cmd.char_en)
    else $error("character taken while busy");
`endif

endmodule

>>> rtl/core/ts2ep_dpath.sv
`timescale 1ns / 1ps
// Datapath: field accumulators, calendar arithmetic, shared 1e9 multiplier, output register.
// Depends on ts2ep_pkg.
module ts2ep_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  ts2ep_pkg::dp_cmd_t                 cmd,
  output ts2ep_pkg::dp_stat_t                stat,
  input  logic [7:0]                         character,
  input  logic                               first,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [ts2ep_pkg::EPOCH_W-1:0]      unix_ns,
  output logic                               valid_res
);

  // ---------------- character intake ----------------
  logic                               active;
  logic [ts2ep_pkg::OFF_W-1:0]        char_offset;
  logic [ts2ep_pkg::YEAR_W-1:0]       year_acc;
  logic [ts2ep_pkg::FIELD_W-1:0]      month_acc;
  logic [ts2ep_pkg::FIELD_W-1:0]      day_acc;
  logic [ts2ep_pkg::FIELD_W-1:0]      hour_acc;
  logic [ts2ep_pkg::FIELD_W-1:0]      minute_acc;
  logic [ts2ep_pkg::FIELD_W-1:0]      second_acc;
  logic [ts2ep_pkg::FRAC_W-1:0]       fraction_acc;
  logic                               digit_error;

  logic                               take;
  logic [ts2ep_pkg::OFF_W-1:0]        off;
  logic                               is_digit;
  logic [ts2ep_pkg::DIGIT_W-1:0]      digit;
  logic in_year, in_month, in_day, in_hour, in_min, in_sec, in_frac, in_field;
  logic [ts2ep_pkg::YEAR_W-1:0]       year_base;
  logic [ts2ep_pkg::FIELD_W-1:0]      month_base, day_base, hour_base, minute_base, second_base;
  logic [ts2ep_pkg::FRAC_W-1:0]       fraction_base;

  always_comb begin
    off      = first ? '0 : char_offset;
    take     = cmd.char_en && (first || active);
    is_digit = (character >= ts2ep_pkg::CHAR_ZERO) && (character <= ts2ep_pkg::CHAR_NINE);
    digit    = is_digit ? ts2ep_pkg::DIGIT_W'(character - ts2ep_pkg::CHAR_ZERO) : '0;

    in_year  = (off <= ts2ep_pkg::OFF_YEAR_END);
    in_month = (off == ts2ep_pkg::OFF_MON0)  || (off == ts2ep_pkg::OFF_MON1);
    in_day   = (off == ts2ep_pkg::OFF_DAY0)  || (off == ts2ep_pkg::OFF_DAY1);
    in_hour  = (off == ts2ep_pkg::OFF_HOUR0) || (off == ts2ep_pkg::OFF_HOUR1);
    in_min   = (off == ts2ep_pkg::OFF_MIN0)  || (off == ts2ep_pkg::OFF_MIN1);
    in_sec   = (off == ts2ep_pkg::OFF_SEC0)  || (off == ts2ep_pkg::OFF_SEC1);
    in_frac  = (off >= ts2ep_pkg::OFF_FRAC0) && (off <= ts2ep_pkg::OFF_LAST);
    in_field = in_year || in_month || in_day || in_hour || in_min || in_sec || in_frac;

    // A start mark clears every field before this character lands
    year_base     = first ? '0 : year_acc;
    month_base    = first ? '0 : month_acc;
    day_base      = first ? '0 : day_acc;
    hour_base     = first ? '0 : hour_acc;
    minute_base   = first ? '0 : minute_acc;
    second_base   = first ? '0 : second_acc;
    fraction_base = first ? '0 : fraction_acc;

    stat.last_char = (first || active) && (off >= ts2ep_pkg::OFF_LAST);
    stat.out_full  = out_valid;
  end

  function automatic logic [ts2ep_pkg::FIELD_W-1:0] shift_in2(
    input logic [ts2ep_pkg::FIELD_W-1:0] acc,
    input logic [ts2ep_pkg::DIGIT_W-1:0] d
  );
    return ts2ep_pkg::FIELD_W'(acc * ts2ep_pkg::FIELD_W'(10)) + ts2ep_pkg::FIELD_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      char_offset  <= '0;
      year_acc     <= '0;
      month_acc    <= '0;
      day_acc      <= '0;
      hour_acc     <= '0;
      minute_acc   <= '0;
      second_acc   <= '0;
      fraction_acc <= '0;
      digit_error  <= 1'b0;
    end else if (take) begin
      active      <= !(off >= ts2ep_pkg::OFF_LAST);
      char_offset <= ts2ep_pkg::OFF_W'(off + 1'b1);
      year_acc    <= in_year ? ts2ep_pkg::YEAR_W'(year_base * ts2ep_pkg::YEAR_W'(10)) +
                               ts2ep_pkg::YEAR_W'(digit) : year_base;
      month_acc   <= in_month ? shift_in2(month_base, digit) : month_base;
      day_acc     <= in_day   ? shift_in2(day_base, digit)   : day_base;
      hour_acc    <= in_hour  ? shift_in2(hour_base, digit)  : hour_base;
      minute_acc  <= in_min   ? shift_in2(minute_base, digit) : minute_base;
      second_acc  <= in_sec   ? shift_in2(second_base, digit) : second_base;
      fraction_acc <= in_frac ? ts2ep_pkg::FRAC_W'(fraction_base * ts2ep_pkg::FRAC_W'(10)) +
                                ts2ep_pkg::FRAC_W'(digit) : fraction_base;
      digit_error <= (!first && digit_error) || (in_field && !is_digit);
    end
  end

  // ---------------- step 1: month normalization, seconds of day ----------------
  logic [ts2ep_pkg::FIELD_W-1:0] mm1;
  logic [ts2ep_pkg::M12_W-1:0]   m12_prod;
  logic [ts2ep_pkg::MI_W-1:0]    m_carry;
  logic [ts2ep_pkg::MI_W-1:0]    mi_raw;
  logic [ts2ep_pkg::MI_W-1:0]    mi_norm;
  logic [ts2ep_pkg::MI_W-1:0]    y_carry;
  logic                          y_dec;
  logic                          feb_adj;
  logic [ts2ep_pkg::YP_W-1:0]    yp_norm;
  logic [ts2ep_pkg::HMS_W-1:0]   hms_norm;

  always_comb begin
    mm1      = month_acc - 1'b1;
    m12_prod = ts2ep_pkg::M12_W'(mm1) * ts2ep_pkg::RECIP_12;
    m_carry  = m12_prod[ts2ep_pkg::RECIP_12_SH +: ts2ep_pkg::MI_W];
    mi_raw   = ts2ep_pkg::MI_W'(ts2ep_pkg::M12_W'(mm1) -
                                ts2ep_pkg::M12_W'(m_carry) * ts2ep_pkg::MONTHS_PER_YEAR);
    // Month zero is December of the year before
    if (month_acc == '0) begin
      mi_norm = ts2ep_pkg::MI_DEC;
      y_carry = '0;
      y_dec   = 1'b1;
    end else begin
      mi_norm = mi_raw;
      y_carry = m_carry;
      y_dec   = 1'b0;
    end
    // January and February belong to the March-based year before
    feb_adj  = (mi_norm < ts2ep_pkg::MI_MAR);
    yp_norm  = ts2ep_pkg::YP_W'((ts2ep_pkg::YP_W + 1)'(year_acc) + ts2ep_pkg::YEAR_SHIFT +
                                (ts2ep_pkg::YP_W + 1)'(y_carry) -
                                (ts2ep_pkg::YP_W + 1)'(y_dec) -
                                (ts2ep_pkg::YP_W + 1)'(feb_adj));
    hms_norm = ts2ep_pkg::HMS_W'(hour_acc) * ts2ep_pkg::SECS_PER_HOUR +
               ts2ep_pkg::HMS_W'(minute_acc) * ts2ep_pkg::SECS_PER_MIN +
               ts2ep_pkg::HMS_W'(second_acc);
  end

  logic [ts2ep_pkg::YP_W-1:0]  yp;
  logic [ts2ep_pkg::MI_W-1:0]  mi;
  logic [ts2ep_pkg::HMS_W-1:0] hms;

  always_ff @(posedge clk) begin
    if (cmd.ld_norm) begin
      yp  <= yp_norm;
      mi  <= mi_norm;
      hms <= hms_norm;
    end
  end

  // ---------------- step 2: leap-year quotients ----------------
  logic [ts2ep_pkg::PQ_W-1:0]   p100;
  logic [ts2ep_pkg::PQ_W-1:0]   p400;
  logic [ts2ep_pkg::Q4_W-1:0]   q4_div;
  logic [ts2ep_pkg::Y365_W-1:0] y365;
  logic [ts2ep_pkg::Q4_W-1:0]   q4;
  logic [ts2ep_pkg::Q100_W-1:0] q100;
  logic [ts2ep_pkg::Q400_W-1:0] q400;

  assign q4_div = yp[ts2ep_pkg::YP_W-1:2];
  assign p100   = ts2ep_pkg::PQ_W'(yp) * ts2ep_pkg::RECIP_100;
  assign p400   = ts2ep_pkg::PQ_W'(q4_div) * ts2ep_pkg::RECIP_100;

  always_ff @(posedge clk) begin
    if (cmd.ld_div) begin
      y365 <= ts2ep_pkg::Y365_W'(yp) * ts2ep_pkg::DAYS_PER_YEAR;
      q4   <= q4_div;
      q100 <= p100[ts2ep_pkg::RECIP_100_SH +: ts2ep_pkg::Q100_W];
      q400 <= p400[ts2ep_pkg::RECIP_100_SH +: ts2ep_pkg::Q400_W];
    end
  end

  // ---------------- step 3: day count ----------------
  logic [ts2ep_pkg::DAYS_W-1:0] days;

  always_ff @(posedge clk) begin
    if (cmd.ld_days) begin
      days <= ts2ep_pkg::DAYS_W'(y365) + ts2ep_pkg::DAYS_W'(q4) + ts2ep_pkg::DAYS_W'(q400) +
              ts2ep_pkg::DAYS_W'(ts2ep_pkg::month_day_offset(mi)) +
              ts2ep_pkg::DAYS_W'(day_acc) - ts2ep_pkg::DAYS_W'(q100) -
              ts2ep_pkg::DAY_BIAS - ts2ep_pkg::DAYS_W'(1);
    end
  end

  // ---------------- step 4: second count ----------------
  logic [ts2ep_pkg::SECS_W-1:0] secs;

  // Sign-extend the day count to the full width before scaling by 86400
  always_ff @(posedge clk) begin
    if (cmd.ld_secs) begin
      secs <= ts2ep_pkg::SECS_W'($signed(ts2ep_pkg::SECS_W'($signed(days))) *
                                 $signed(ts2ep_pkg::SECS_W'(ts2ep_pkg::SECS_PER_DAY))) +
              ts2ep_pkg::SECS_W'(hms);
    end
  end

  // ---------------- steps 5-6: shared 32x30 multiplier by 1e9 ----------------
  logic [ts2ep_pkg::EPOCH_W-1:0] secs64;
  logic [ts2ep_pkg::HALF_W-1:0]  mul_a;
  logic [ts2ep_pkg::MULP_W-1:0]  mul_p;
  logic [ts2ep_pkg::MULP_W-1:0]  prod_lo;
  logic [ts2ep_pkg::HALF_W-1:0]  prod_hi;

  assign secs64 = {{(ts2ep_pkg::EPOCH_W - ts2ep_pkg::SECS_W){secs[ts2ep_pkg::SECS_W-1]}}, secs};
  assign mul_a  = cmd.mul_hi ? secs64[ts2ep_pkg::EPOCH_W-1:ts2ep_pkg::HALF_W]
                             : secs64[ts2ep_pkg::HALF_W-1:0];
  assign mul_p  = ts2ep_pkg::MULP_W'(mul_a) * ts2ep_pkg::MULP_W'(ts2ep_pkg::NANOS_PER_SEC);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p[ts2ep_pkg::HALF_W-1:0];
    end
  end

  // ---------------- step 7: final sum into the output register ----------------
  logic [ts2ep_pkg::FRAC_W-1:0] frac_ns;

  assign frac_ns = ts2ep_pkg::FRAC_W'(fraction_acc * ts2ep_pkg::FRAC_SCALE);

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      unix_ns   <= ts2ep_pkg::EPOCH_W'(prod_lo) + {prod_hi, {ts2ep_pkg::HALF_W{1'b0}}} +
                   ts2ep_pkg::EPOCH_W'(frac_ns);
      valid_res <= !digit_error && (month_acc >= ts2ep_pkg::FIELD_W'(1)) &&
                   (month_acc <= ts2ep_pkg::FIELD_W'(12));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/iso_timestamp_to_epoch_nanos.sv
`timescale 1ns / 1ps
// Top level of the ISO-8601 timestamp to Unix epoch nanoseconds converter.
// Depends on ts2ep_pkg, ts2ep_ctrl and ts2ep_dpath.

// Feed the characters of "YYYY-MM-DDTHH:MM:SS.nnnnnnnnnZ" one transaction at a
// time, with first set on the opening year digit. Characters are taken at one
// per cycle while in_ready is high; separators are skipped, and characters
// with no string open (after the last fraction digit, before any start mark)
// are taken and dropped. The last fraction digit launches the calendar
// arithmetic (month normalization, leap-year quotients, day count, second
// count, two passes through the one shared 32x30 multiplier by 1e9, final
// sum), during which in_ready stays low. The final sum step holds for as long
// as an earlier result still waits in the output register. The result sits in
// an output register, so the next string can be taken while an earlier result
// waits for out_ready. A new start mark in the middle of a string drops that
// string without a result. unix_ns wraps modulo 2^64 (dates before 1970 come
// out as two's complement); valid_res drops to 0 on a non-digit in a digit
// position or a month outside 1..12, though unix_ns is still computed with
// such a character as zero.
module iso_timestamp_to_epoch_nanos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        character,
  input  logic                              first,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ts2ep_pkg::EPOCH_W-1:0]     unix_ns,
  output logic                              valid_res
);

  ts2ep_pkg::dp_cmd_t  cmd;
  ts2ep_pkg::dp_stat_t stat;

  // Sequencer: owns the input handshake and steps the calendar datapath
  ts2ep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: field capture, calendar math and the result register
  ts2ep_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .character   (character),
    .first       (first),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .unix_ns     (unix_ns),
    .valid_res   (valid_res)
  );

endmodule
